// ===== src/mcf_pkg.sv =====
// ----------------------------------------------------------------------------
// Motor command framer package
// Shared types, codes and frame constants for the motor command framer.
// ----------------------------------------------------------------------------
`default_nettype none

package mcf_pkg;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int IDX_W   = 4;

  typedef enum logic [2:0] {
    ACT_ENABLE   = 3'd0,
    ACT_SPEED    = 3'd1,
    ACT_POSITION = 3'd2,
    ACT_REPORT   = 3'd3,
    ACT_READ_POS = 3'd4,
    ACT_HOME     = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    REG_RPM_LIMIT       = 2'd0,
    REG_POS_MODE_LIMIT  = 2'd1,
    REG_HOME_MODE_LIMIT = 2'd2,
    REG_FRAME_CAPACITY  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT,
    ST_ERROR
  } state_t;

  typedef enum logic [1:0] {
    CHK_RPM,
    CHK_MODE,
    CHK_LEN
  } chk_t;

  typedef struct packed {
    logic [15:0] rpm_limit;
    logic [7:0]  pos_mode_limit;
    logic [7:0]  home_mode_limit;
    logic [7:0]  frame_capacity;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  motor_addr;
    logic        enable_on;
    logic [7:0]  direction;
    logic [15:0] speed_rpm;
    logic [7:0]  accel;
    logic [31:0] pulse_count;
    logic [7:0]  mode_code;
    logic [15:0] report_period;
  } cmd_t;

  localparam logic [15:0] RPM_LIMIT_RST       = 16'd3000;
  localparam logic [7:0]  POS_MODE_LIMIT_RST  = 8'd2;
  localparam logic [7:0]  HOME_MODE_LIMIT_RST = 8'd4;
  localparam logic [7:0]  FRAME_CAPACITY_RST  = 8'd255;

  localparam logic [7:0] TAIL_BYTE     = 8'h6B;
  localparam logic [7:0] SYNC_NOW      = 8'h00;
  localparam logic [7:0] FN_ENABLE     = 8'hF3;
  localparam logic [7:0] FN_SPEED      = 8'hF6;
  localparam logic [7:0] FN_POSITION   = 8'hFD;
  localparam logic [7:0] FN_REPORT     = 8'h11;
  localparam logic [7:0] FN_READ_POS   = 8'h36;
  localparam logic [7:0] FN_HOME       = 8'h9A;
  localparam logic [7:0] AUX_ENABLE    = 8'hAB;
  localparam logic [7:0] AUX_REPORT    = 8'h18;
  localparam logic [7:0] INFO_POSITION = 8'h36;

  // Total frame length in bytes, including address, code and tail.
  function automatic logic [IDX_W-1:0] frame_len(logic [2:0] act);
    logic [IDX_W-1:0] len;
    case (act)
      ACT_ENABLE:   len = 4'd6;
      ACT_SPEED:    len = 4'd8;
      ACT_POSITION: len = 4'd13;
      ACT_REPORT:   len = 4'd7;
      ACT_READ_POS: len = 4'd3;
      ACT_HOME:     len = 4'd5;
      default:      len = 4'd0;
    endcase
    return len;
  endfunction

  // Byte at position idx of the frame; the tail sits at the last position.
  function automatic logic [7:0] frame_byte_at(cmd_t c, logic [IDX_W-1:0] idx);
    logic [7:0] b;
    b = TAIL_BYTE;
    if (idx == 4'd0) begin
      b = c.motor_addr;
    end else begin
      case (c.action)
        ACT_ENABLE: begin
          case (idx)
            4'd1:    b = FN_ENABLE;
            4'd2:    b = AUX_ENABLE;
            4'd3:    b = {7'd0, c.enable_on};
            4'd4:    b = SYNC_NOW;
            default: b = TAIL_BYTE;
          endcase
        end
        ACT_SPEED: begin
          case (idx)
            4'd1:    b = FN_SPEED;
            4'd2:    b = c.direction;
            4'd3:    b = c.speed_rpm[15:8];
            4'd4:    b = c.speed_rpm[7:0];
            4'd5:    b = c.accel;
            4'd6:    b = SYNC_NOW;
            default: b = TAIL_BYTE;
          endcase
        end
        ACT_POSITION: begin
          case (idx)
            4'd1:    b = FN_POSITION;
            4'd2:    b = c.direction;
            4'd3:    b = c.speed_rpm[15:8];
            4'd4:    b = c.speed_rpm[7:0];
            4'd5:    b = c.accel;
            4'd6:    b = c.pulse_count[31:24];
            4'd7:    b = c.pulse_count[23:16];
            4'd8:    b = c.pulse_count[15:8];
            4'd9:    b = c.pulse_count[7:0];
            4'd10:   b = c.mode_code;
            4'd11:   b = SYNC_NOW;
            default: b = TAIL_BYTE;
          endcase
        end
        ACT_REPORT: begin
          case (idx)
            4'd1:    b = FN_REPORT;
            4'd2:    b = AUX_REPORT;
            4'd3:    b = INFO_POSITION;
            4'd4:    b = c.report_period[15:8];
            4'd5:    b = c.report_period[7:0];
            default: b = TAIL_BYTE;
          endcase
        end
        ACT_READ_POS: begin
          case (idx)
            4'd1:    b = FN_READ_POS;
            default: b = TAIL_BYTE;
          endcase
        end
        ACT_HOME: begin
          case (idx)
            4'd1:    b = FN_HOME;
            4'd2:    b = c.mode_code;
            4'd3:    b = SYNC_NOW;
            default: b = TAIL_BYTE;
          endcase
        end
        default: b = TAIL_BYTE;
      endcase
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== src/mcf_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Motor command channel
// Valid/ready channel that carries one driver command per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcf_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  motor_addr;
  logic        enable_on;
  logic [7:0]  direction;
  logic [15:0] speed_rpm;
  logic [7:0]  accel;
  logic [31:0] pulse_count;
  logic [7:0]  mode_code;
  logic [15:0] report_period;

  modport source (
    output valid, action, motor_addr, enable_on, direction, speed_rpm, accel,
           pulse_count, mode_code, report_period,
    input  ready
  );

  modport sink (
    input  valid, action, motor_addr, enable_on, direction, speed_rpm, accel,
           pulse_count, mode_code, report_period,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/mcf_frame_if.sv =====
// ----------------------------------------------------------------------------
// Motor frame byte channel
// Valid/ready channel that carries one frame byte or error result per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcf_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;
  logic       status;

  modport source (
    output valid, frame_byte, last_byte, status,
    input  ready
  );

  modport sink (
    input  valid, frame_byte, last_byte, status,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/mcf_regs.sv =====
// ----------------------------------------------------------------------------
// Motor command framer registers
// APB-style register file holding the parameter check limits.
// ----------------------------------------------------------------------------
`default_nettype none

module mcf_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mcf_pkg::PADDR_W-1:0] paddr,
  input  wire logic [mcf_pkg::PDATA_W-1:0] pwdata,
  output logic      [mcf_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  output mcf_pkg::cfg_t                    cfg
);
  import mcf_pkg::*;

  logic     wr_en;
  reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rpm_limit       <= RPM_LIMIT_RST;
      cfg.pos_mode_limit  <= POS_MODE_LIMIT_RST;
      cfg.home_mode_limit <= HOME_MODE_LIMIT_RST;
      cfg.frame_capacity  <= FRAME_CAPACITY_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RPM_LIMIT:       cfg.rpm_limit       <= pwdata[15:0];
        REG_POS_MODE_LIMIT:  cfg.pos_mode_limit  <= pwdata[7:0];
        REG_HOME_MODE_LIMIT: cfg.home_mode_limit <= pwdata[7:0];
        REG_FRAME_CAPACITY:  cfg.frame_capacity  <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RPM_LIMIT:       prdata = {16'd0, cfg.rpm_limit};
      REG_POS_MODE_LIMIT:  prdata = {24'd0, cfg.pos_mode_limit};
      REG_HOME_MODE_LIMIT: prdata = {24'd0, cfg.home_mode_limit};
      REG_FRAME_CAPACITY:  prdata = {24'd0, cfg.frame_capacity};
    endcase
  end

endmodule

`default_nettype wire

// ===== src/motor_command_framer_unit.sv =====
// ----------------------------------------------------------------------------
// Motor command framer
// Checks one stepper-driver command and sends its frame one byte per item.
// ----------------------------------------------------------------------------
// One command is taken at a time. After it is accepted, a single shared
// comparator runs three check steps (speed against the rpm limit, mode against
// the position or homing limit, frame length against capacity), one per cycle.
// A command that passes then sends its frame, one byte per cycle while the
// sink takes them, with last_byte on the tail; one that fails sends a single
// item with status 1. The limits live in an APB-style register file at byte
// addresses 0, 4, 8 and 12; the user must write them only while the block is
// idle, and the block itself does not enforce this.
`default_nettype none

module motor_command_framer_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  mcf_cmd_if.sink                          cmd,
  mcf_frame_if.source                      frame,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mcf_pkg::PADDR_W-1:0] paddr,
  input  wire logic [mcf_pkg::PDATA_W-1:0] pwdata,
  output logic      [mcf_pkg::PDATA_W-1:0] prdata,
  output logic                             pready
);
  import mcf_pkg::*;

  cfg_t   cfg;
  state_t state, state_next;
  chk_t   chk, chk_next;
  cmd_t   cmd_q;
  logic   err, err_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [IDX_W-1:0] len, len_m1;

  logic        cmp_en;
  logic [15:0] cmp_a, cmp_b;
  logic        cmp_gt;

  logic        out_valid;
  logic [7:0]  out_byte, out_byte_next;
  logic        out_last, out_last_next;
  logic        out_status, out_status_next;
  logic        load_out;
  logic        slot_free;
  logic        accept;

  mcf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign slot_free = !out_valid || frame.ready;
  assign len       = frame_len(cmd_q.action);
  assign len_m1    = len - 4'd1;

  // Shared comparator: operands are chosen by the current check step.
  always_comb begin
    cmp_a  = 16'd0;
    cmp_b  = 16'd0;
    cmp_en = 1'b0;
    unique case (chk)
      CHK_RPM: begin
        cmp_a  = cmd_q.speed_rpm;
        cmp_b  = cfg.rpm_limit;
        cmp_en = (cmd_q.action == ACT_SPEED) || (cmd_q.action == ACT_POSITION);
      end
      CHK_MODE: begin
        cmp_a  = {8'd0, cmd_q.mode_code};
        cmp_b  = (cmd_q.action == ACT_HOME) ? {8'd0, cfg.home_mode_limit}
                                            : {8'd0, cfg.pos_mode_limit};
        cmp_en = (cmd_q.action == ACT_HOME) || (cmd_q.action == ACT_POSITION);
      end
      CHK_LEN: begin
        cmp_a  = {12'd0, len};
        cmp_b  = {8'd0, cfg.frame_capacity};
        cmp_en = 1'b1;
      end
      default: begin
        cmp_en = 1'b0;
      end
    endcase
  end

  assign cmp_gt = cmp_a > cmp_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    chk_next        = chk;
    err_next        = err;
    idx_next        = idx;
    load_out        = 1'b0;
    out_byte_next   = 8'd0;
    out_last_next   = 1'b1;
    out_status_next = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          err_next   = (cmd.motor_addr == 8'd0) || (cmd.action > ACT_HOME);
          chk_next   = CHK_RPM;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (cmp_en && cmp_gt) begin
          err_next = 1'b1;
        end
        unique case (chk)
          CHK_RPM:  chk_next = CHK_MODE;
          CHK_MODE: chk_next = CHK_LEN;
          default: begin
            idx_next   = '0;
            state_next = err_next ? ST_ERROR : ST_EMIT;
          end
        endcase
      end
      ST_EMIT: begin
        if (slot_free) begin
          load_out        = 1'b1;
          out_byte_next   = frame_byte_at(cmd_q, idx);
          out_last_next   = (idx == len_m1);
          out_status_next = 1'b0;
          idx_next        = idx + 4'd1;
          if (idx == len_m1) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_ERROR: begin
        if (slot_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q.action        <= cmd.action;
      cmd_q.motor_addr    <= cmd.motor_addr;
      cmd_q.enable_on     <= cmd.enable_on;
      cmd_q.direction     <= cmd.direction;
      cmd_q.speed_rpm     <= cmd.speed_rpm;
      cmd_q.accel         <= cmd.accel;
      cmd_q.pulse_count   <= cmd.pulse_count;
      cmd_q.mode_code     <= cmd.mode_code;
      cmd_q.report_period <= cmd.report_period;
    end
    chk <= chk_next;
    err <= err_next;
    idx <= idx_next;
    if (load_out) begin
      out_byte   <= out_byte_next;
      out_last   <= out_last_next;
      out_status <= out_status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (frame.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign frame.valid      = out_valid;
  assign frame.frame_byte = out_byte;
  assign frame.last_byte  = out_last;
  assign frame.status     = out_status;

endmodule

`default_nettype wire
